// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge of clk
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/sdcrc_pkg.sv =====
`default_nettype none
package sdcrc_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CRC_BYTES = 8;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  typedef logic [LANES-1:0][CRC_W-1:0] lane_arr_t;
  typedef logic [CRC_BYTES*8-1:0]      crc_block_t;
  typedef logic [2:0]                  byte_idx_t;

  localparam byte_idx_t LAST_IDX = 3'd7;

  function automatic logic [CRC_W-1:0] crc_bit_step(input logic [CRC_W-1:0] crc,
                                                    input logic bit_in);
    logic fb;
    logic [CRC_W-1:0] nxt;
    fb  = crc[CRC_W-1] ^ bit_in;
    nxt = {crc[CRC_W-2:0], 1'b0};
    if (fb) begin
      nxt = nxt ^ CRC_POLY;
    end
    return nxt;
  endfunction

  // advance every lane by the high then the low nibble bit of one byte
  function automatic lane_arr_t lanes_advance(input lane_arr_t lanes,
                                              input logic [7:0] data);
    lane_arr_t res;
    for (int l = 0; l < LANES; l++) begin
      res[l] = crc_bit_step(crc_bit_step(lanes[l], data[7-l]), data[3-l]);
    end
    return res;
  endfunction

  // interleave the lane CRCs into the transmit byte order, first byte on top
  function automatic crc_block_t lanes_pack(input lane_arr_t lanes);
    crc_block_t blk;
    blk = '0;
    for (int k = 0; k < CRC_BYTES; k++) begin
      for (int l = 0; l < LANES; l++) begin
        blk[(CRC_BYTES-1-k)*8 + 7 - l] = lanes[l][15 - 2*k];
        blk[(CRC_BYTES-1-k)*8 + 3 - l] = lanes[l][14 - 2*k];
      end
    end
    return blk;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sdcrc_if.sv =====
`default_nettype none
interface sdcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface sdcrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] crc_byte;
  logic       crc_final;

  modport source (output valid, output crc_byte, output crc_final, input ready);
  modport sink   (input valid, input crc_byte, input crc_final, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sd_four_line_data_crc16.sv =====
// Four-lane CRC16 generator for data blocks on an SD 4-bit bus.
// in_chan (sink): one block byte per transfer, data_byte with block_end set
//   on the final byte. Each byte advances all four lane CRCs by two bits.
// out_chan (source): after a byte with block_end, eight interleaved CRC
//   bytes, crc_final set on the eighth.
// Output: the block's CRC bytes are registered, or wait in the holding buffer
//   below; they follow one per cycle while out_chan.ready is high.
// Throughput: one data byte per cycle while in_chan.ready is high. The CRC
//   bytes drain from a shift register with a one-block holding buffer behind
//   it, so input keeps flowing while a block's CRC is sent. in_chan.ready
//   drops only when that holding buffer is full, i.e. when a second block ends
//   before the first block's CRC has finished draining.
// Stall: with out_chan.ready low the current CRC byte holds.
// Reset (rst_n low, synchronous): lane CRCs clear to zero and any pending
//   CRC output is dropped.
`default_nettype none
`include "assert_macros.svh"
module sd_four_line_data_crc16 (
  input  wire             clk,
  input  wire             rst_n,
  sdcrc_in_if.sink        in_chan,
  sdcrc_out_if.source     out_chan
);

  sdcrc_pkg::lane_arr_t  lane_r, lane_nxt;
  sdcrc_pkg::crc_block_t emit_buf_r, emit_buf_nxt;
  sdcrc_pkg::crc_block_t pend_buf_r, pend_buf_nxt;
  sdcrc_pkg::byte_idx_t  emit_cnt_r, emit_cnt_nxt;
  logic                  emit_vld_r, emit_vld_nxt;
  logic                  pend_vld_r, pend_vld_nxt;

  logic                  in_xfer;
  logic                  out_xfer;
  logic                  emit_done;
  logic                  emit_free;
  sdcrc_pkg::lane_arr_t  lane_adv;
  sdcrc_pkg::crc_block_t snap;

  assign in_chan.ready      = !pend_vld_r;
  assign in_xfer            = in_chan.valid && in_chan.ready;
  assign out_chan.valid     = emit_vld_r;
  assign out_chan.crc_byte  = emit_buf_r[sdcrc_pkg::CRC_BYTES*8-1 -: 8];
  assign out_chan.crc_final = (emit_cnt_r == sdcrc_pkg::LAST_IDX);
  assign out_xfer           = out_chan.valid && out_chan.ready;
  assign emit_done          = out_xfer && (emit_cnt_r == sdcrc_pkg::LAST_IDX);
  assign emit_free          = !emit_vld_r || emit_done;

  assign lane_adv = sdcrc_pkg::lanes_advance(lane_r, in_chan.data_byte);
  assign snap     = sdcrc_pkg::lanes_pack(lane_adv);

  always_comb begin
    lane_nxt     = lane_r;
    emit_buf_nxt = emit_buf_r;
    emit_cnt_nxt = emit_cnt_r;
    emit_vld_nxt = emit_vld_r;
    pend_buf_nxt = pend_buf_r;
    pend_vld_nxt = pend_vld_r;

    // advance or retire the block being sent
    if (out_xfer) begin
      if (emit_done) begin
        emit_cnt_nxt = '0;
        emit_vld_nxt = pend_vld_r;
        emit_buf_nxt = pend_buf_r;
        pend_vld_nxt = 1'b0;
      end else begin
        emit_cnt_nxt = emit_cnt_r + 3'd1;
        emit_buf_nxt = {emit_buf_r[sdcrc_pkg::CRC_BYTES*8-9:0], 8'h00};
      end
    end

    if (in_xfer) begin
      if (in_chan.block_end) begin
        lane_nxt = '0;
        if (emit_free) begin
          emit_buf_nxt = snap;
          emit_cnt_nxt = '0;
          emit_vld_nxt = 1'b1;
        end else begin
          pend_buf_nxt = snap;
          pend_vld_nxt = 1'b1;
        end
      end else begin
        lane_nxt = lane_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r     <= '0;
      emit_cnt_r <= '0;
      emit_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      lane_r     <= lane_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      emit_vld_r <= emit_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_buf_r <= emit_buf_nxt;
    pend_buf_r <= pend_buf_nxt;
  end

  `ASSERT_CLK(a_pend_behind_emit, pend_vld_r |-> emit_vld_r, "pending CRC without active block")
  `ASSERT_CLK(a_end_starts_emit, in_xfer && in_chan.block_end |=> emit_vld_r, "block end did not start CRC output")
  `ASSERT_CLK(a_stall_holds, emit_vld_r && !out_chan.ready |=> emit_vld_r && $stable(emit_cnt_r), "stalled CRC byte moved")
  `ASSERT_NEVER(a_no_overflow, in_xfer && in_chan.block_end && pend_vld_r, "block end accepted with full holding buffer")

endmodule
`default_nettype wire
